// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/lkvc_pkg.sv -----
// Package: types, codes and defaults of the LRU key/value cache.
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_WIDTH_DEF   = 16;

   localparam int KEY_FIELD_W = 16;
   localparam int VAL_FIELD_W = 32;
   localparam int CFG_W       = 5;

   localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } req_op_type;

   typedef struct packed {
      req_op_type                     op;
      logic [KEY_FIELD_W-1:0]         key;
      logic signed [VAL_FIELD_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic                           found;
      logic signed [VAL_FIELD_W-1:0]  read_value;
      logic                           evicted;
      logic [KEY_FIELD_W-1:0]         evicted_key;
   } rsp_item_type;

endpackage

// ----- hdl/lkvc_store.sv -----
// Entry store: associative key compare, recency ranks, hit/evict/insert update.
`include "assert_macros.svh"

module lkvc_store #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        proc,
   input  lkvc_pkg::req_item_type      req,
   input  logic [lkvc_pkg::CFG_W-1:0]  capacity,
   output lkvc_pkg::rsp_item_type      rsp
);

   localparam int SKW    = (KEY_WIDTH < lkvc_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                               : lkvc_pkg::KEY_FIELD_W;
   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;
   localparam int VW     = lkvc_pkg::VAL_FIELD_W;

   logic [SKW-1:0]         keys_ff  [MAX_ENTRIES];
   logic [VW-1:0]          values_ff[MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_ff  [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_in  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic [SKW-1:0]         key_w;
   logic [MAX_ENTRIES-1:0] hit_vec, lru_vec, free_vec, slot_vec, wr_val_vec, wr_key_vec;
   logic                   hit_any, is_put, full, do_evict, do_insert, can_evict;
   logic [RANK_W-1:0]      hit_rank;
   logic [VW-1:0]          hit_value;
   logic [SKW-1:0]         lru_key;
   logic [CNT_W-1:0]       lru_rank;
   logic [CMP_W-1:0]       eff_cap;

   assign key_w    = req.key[SKW-1:0];
   assign is_put   = (req.op == lkvc_pkg::OP_PUT);
   assign lru_rank = count_ff - CNT_W'(1);

   always_comb begin
      logic seen;
      seen      = 1'b0;
      hit_rank  = '0;
      hit_value = '0;
      lru_key   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (keys_ff[i] == key_w);
         lru_vec[i]  = valid_ff[i] && (CNT_W'(rank_ff[i]) == lru_rank);
         free_vec[i] = !valid_ff[i] && !seen;
         if (!valid_ff[i]) begin
            seen = 1'b1;
         end
         hit_rank  = hit_rank  | (hit_vec[i] ? rank_ff[i]   : '0);
         hit_value = hit_value | (hit_vec[i] ? values_ff[i] : '0);
         lru_key   = lru_key   | (lru_vec[i] ? keys_ff[i]   : '0);
      end
   end

   always_comb begin
      if (capacity == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CMP_W'(capacity);
      end
   end

   assign hit_any   = |hit_vec;
   assign full      = CMP_W'(count_ff) >= eff_cap;
   assign can_evict = is_put && !hit_any && full && (|lru_vec);
   assign do_evict  = proc && can_evict;
   assign slot_vec  = do_evict ? lru_vec : free_vec;
   assign do_insert = proc && is_put && !hit_any && (|slot_vec);

   assign wr_key_vec = do_insert ? slot_vec : '0;
   assign wr_val_vec = (proc && is_put && hit_any) ? hit_vec : wr_key_vec;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (do_insert) begin
         valid_in = valid_ff | slot_vec;
         if (!do_evict) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (proc && hit_any) begin
            if (hit_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end else if (do_insert) begin
            if (slot_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp.found       = hit_any;
      rsp.read_value  = (hit_any && !is_put) ? hit_value : '0;
      rsp.evicted     = can_evict;
      rsp.evicted_key = can_evict ? lkvc_pkg::KEY_FIELD_W'(lru_key) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
         if (wr_key_vec[i]) begin
            keys_ff[i] <= key_w;
         end
         if (wr_val_vec[i]) begin
            values_ff[i] <= req.value;
         end
      end
   end

   `ASSERT_ALWAYS(a_count_matches_valid, clock, reset, CNT_W'($countones(valid_ff)) == count_ff)
   `ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   `ASSERT_IMPLIES(a_evict_only_put_miss, clock, reset, proc && rsp.evicted,
                   is_put && !rsp.found)
   `ASSERT_NEXT(a_get_keeps_count, clock, reset, proc && !is_put, $stable(count_ff))

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// Top level: LRU key/value cache with request register, result register and CSR.
//
// Request channel (req_*): req_type selects get or put, req_lookup_key is the
// key and req_store_value the value a put stores. An item is taken at a clock
// edge where req_valid is high and req_stall is low.
// Result channel (rsp_*): one result item per request, in request order. It is
// taken at an edge where rsp_valid is high and rsp_stall is low.
// CSR channel (csr_*): csr_wdata writes capacity_ff when csr_valid and
// csr_ready are both high; csr_ready is always high. Write only while idle.
// The request is held in the input register and its result in the result register.
// Throughput: one item per cycle while rsp_stall is low; the key compare over
// all entries and the rank update are combinational between the two registers.
// When rsp_stall holds a waiting result, one more request is held in the input
// register and then req_stall rises until the result is taken.
// Reset (synchronous, active high) empties the store, clears both registers
// and sets the capacity to 16; there is no clearing pass.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_type,
   input  logic [lkvc_pkg::KEY_FIELD_W-1:0]         req_lookup_key,
   input  logic signed [lkvc_pkg::VAL_FIELD_W-1:0]  req_store_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_found,
   output logic signed [lkvc_pkg::VAL_FIELD_W-1:0]  rsp_read_value,
   output logic                                     rsp_evicted,
   output logic [lkvc_pkg::KEY_FIELD_W-1:0]         rsp_evicted_key,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [lkvc_pkg::CFG_W-1:0]               csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   lkvc_pkg::req_item_type        in_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_item_type        rsp_ff, rsp_w;
   logic [lkvc_pkg::CFG_W-1:0]    capacity_ff;
   logic                          proc, accept;

   assign proc      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= lkvc_pkg::CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.op    <= lkvc_pkg::req_op_type'(req_type);
         in_ff.key   <= req_lookup_key;
         in_ff.value <= req_store_value;
      end
      if (proc) begin
         rsp_ff <= rsp_w;
      end
   end

   lkvc_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .proc     (proc),
      .req      (in_ff),
      .capacity (capacity_ff),
      .rsp      (rsp_w)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_evicted     = rsp_ff.evicted;
   assign rsp_evicted_key = rsp_ff.evicted_key;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench: random and directed get/put traffic against an LRU shadow of the key/value cache.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = lkvc_pkg::MAX_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 250;

   class lru_shadow_store;
      bit [lkvc_pkg::KEY_FIELD_W-1:0]        keys[ENTRIES];
      bit signed [lkvc_pkg::VAL_FIELD_W-1:0] values[ENTRIES];
      bit                                    live[ENTRIES];
      bit [3:0]                              rank[ENTRIES];
      int unsigned                           live_count;
      bit [lkvc_pkg::CFG_W-1:0]              capacity;
      lkvc_pkg::rsp_item_type                awaited_results[$];
      int unsigned                           mismatches;
      int unsigned                           requests;
      int unsigned                           hits;
      int unsigned                           evictions;
      int unsigned                           settings;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         live_count = 0;
         capacity   = lkvc_pkg::CAPACITY_RESET;
      endfunction

      function void set_capacity(bit [lkvc_pkg::CFG_W-1:0] cap);
         capacity = cap;
         settings++;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // work out the result of one accepted request and update the shadow
      function void note_request(lkvc_pkg::req_op_type op,
                                 bit [lkvc_pkg::KEY_FIELD_W-1:0] key,
                                 bit signed [lkvc_pkg::VAL_FIELD_W-1:0] value);
         lkvc_pkg::rsp_item_type res;
         int                     hit;
         int                     slot;
         int                     oldest;
         int unsigned            limit;
         bit [3:0]               old_rank;
         res  = '0;
         hit  = -1;
         slot = -1;
         requests++;
         for (int i = 0; i < ENTRIES; i++)
            if (live[i] && keys[i] == key) hit = i;
         if (hit >= 0) begin
            hits++;
            res.found = 1'b1;
            if (op == lkvc_pkg::OP_PUT) values[hit] = value;
            else res.read_value = values[hit];
            old_rank = rank[hit];
            for (int i = 0; i < ENTRIES; i++)
               if (live[i] && rank[i] < old_rank) rank[i]++;
            rank[hit] = '0;
         end else if (op == lkvc_pkg::OP_PUT) begin
            limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
            if (live_count >= limit) begin
               oldest = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (live[i] && (oldest < 0 || rank[i] > rank[oldest])) oldest = i;
               if (oldest >= 0) begin
                  evictions++;
                  res.evicted     = 1'b1;
                  res.evicted_key = keys[oldest];
                  live[oldest]    = 1'b0;
                  live_count--;
                  slot = oldest;
               end
            end
            if (slot < 0)
               for (int i = 0; i < ENTRIES; i++)
                  if (!live[i] && slot < 0) slot = i;
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (live[i]) rank[i]++;
               keys[slot]   = key;
               values[slot] = value;
               live[slot]   = 1'b1;
               rank[slot]   = '0;
               live_count++;
            end
         end
         awaited_results.push_back(res);
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_result(lkvc_pkg::rsp_item_type got);
         lkvc_pkg::rsp_item_type want;
         if (awaited_results.size() == 0) begin
            flag_mismatch("result item with nothing outstanding");
         end else begin
            want = awaited_results.pop_front();
            if (got.found !== want.found)
               flag_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.read_value !== want.read_value)
               flag_mismatch($sformatf("read_value %0d, want %0d",
                                       got.read_value, want.read_value));
            if (got.evicted !== want.evicted)
               flag_mismatch($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
            if (got.evicted_key !== want.evicted_key)
               flag_mismatch($sformatf("evicted_key %h, want %h",
                                       got.evicted_key, want.evicted_key));
         end
      endtask
   endclass

   logic                                    clock;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_stall;
   logic                                    req_type;
   logic [lkvc_pkg::KEY_FIELD_W-1:0]        req_lookup_key;
   logic signed [lkvc_pkg::VAL_FIELD_W-1:0] req_store_value;
   logic                                    rsp_valid;
   logic                                    rsp_stall;
   logic                                    rsp_found;
   logic signed [lkvc_pkg::VAL_FIELD_W-1:0] rsp_read_value;
   logic                                    rsp_evicted;
   logic [lkvc_pkg::KEY_FIELD_W-1:0]        rsp_evicted_key;
   logic                                    csr_valid;
   logic                                    csr_ready;
   logic [lkvc_pkg::CFG_W-1:0]              csr_wdata;

   lru_shadow_store shadow;
   int unsigned     idle_pct;
   int unsigned     cycles;

   lru_key_value_cache u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_lookup_key  (req_lookup_key),
      .req_store_value (req_store_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit roll_idle();
      return (idle_pct != 0) && ($urandom_range(99) < idle_pct);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(lkvc_pkg::req_op_type op,
                               bit [lkvc_pkg::KEY_FIELD_W-1:0] key,
                               bit signed [lkvc_pkg::VAL_FIELD_W-1:0] value);
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= op;
      req_lookup_key  <= key;
      req_store_value <= value;
      do @(posedge clock); while (req_stall);
      shadow.note_request(op, key, value);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(bit [lkvc_pkg::CFG_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock); while (!csr_ready);
      shadow.set_capacity(cap);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random traffic over a small key pool so that hits and evictions are common
   task automatic random_phase(bit [lkvc_pkg::CFG_W-1:0] cap, int unsigned n);
      bit [lkvc_pkg::KEY_FIELD_W-1:0]        pool[24];
      bit [lkvc_pkg::KEY_FIELD_W-1:0]        key;
      bit signed [lkvc_pkg::VAL_FIELD_W-1:0] value;
      int unsigned                           pool_n;
      int unsigned                           roll;
      lkvc_pkg::req_op_type                  op;
      pool_n = ((cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap)) + 4;
      foreach (pool[i]) pool[i] = lkvc_pkg::KEY_FIELD_W'($urandom());
      write_capacity(cap);
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 85) key = pool[$urandom_range(pool_n - 1)];
         else if (roll < 90) key = {lkvc_pkg::KEY_FIELD_W{roll[0]}};
         else key = lkvc_pkg::KEY_FIELD_W'($urandom());
         roll = $urandom_range(99);
         if (roll < 3) value = 32'sh8000_0000;
         else if (roll < 6) value = 32'sh7FFF_FFFF;
         else value = $urandom();
         op = lkvc_pkg::req_op_type'($urandom_range(1));
         send_request(op, key, value);
      end
      drain();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= roll_idle();
      end
   end

   initial begin
      lkvc_pkg::rsp_item_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.found       = rsp_found;
            got.read_value  = rsp_read_value;
            got.evicted     = rsp_evicted;
            got.evicted_key = rsp_evicted_key;
            shadow.check_result(got);
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      bit [lkvc_pkg::CFG_W-1:0] caps[8];
      shadow          = new();
      idle_pct        = 10;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = lkvc_pkg::OP_GET;
      req_lookup_key  = '0;
      req_store_value = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store, extreme keys and values, update of a present key
      send_request(lkvc_pkg::OP_GET, 16'h0000, 32'sd0);
      send_request(lkvc_pkg::OP_PUT, 16'h0000, 32'sh8000_0000);
      send_request(lkvc_pkg::OP_PUT, 16'hFFFF, 32'sh7FFF_FFFF);
      send_request(lkvc_pkg::OP_GET, 16'h0000, 32'sd0);
      send_request(lkvc_pkg::OP_GET, 16'hFFFF, 32'sd0);
      send_request(lkvc_pkg::OP_PUT, 16'h0000, -32'sd1);
      send_request(lkvc_pkg::OP_GET, 16'h0000, 32'sd0);
      send_request(lkvc_pkg::OP_GET, 16'h1234, 32'sd0);
      drain();
      // capacity below the current count
      write_capacity(5'd1);
      send_request(lkvc_pkg::OP_PUT, 16'hA5A5, 32'sd1);
      send_request(lkvc_pkg::OP_PUT, 16'h5A5A, 32'sd2);
      send_request(lkvc_pkg::OP_GET, 16'hA5A5, 32'sd0);
      send_request(lkvc_pkg::OP_GET, 16'hFFFF, 32'sd0);
      send_request(lkvc_pkg::OP_GET, 16'h5A5A, 32'sd0);
      drain();
      // capacity zero acts as one
      write_capacity(5'd0);
      send_request(lkvc_pkg::OP_PUT, 16'h0F0F, 32'sh1234_5678);
      send_request(lkvc_pkg::OP_GET, 16'h0F0F, 32'sd0);
      send_request(lkvc_pkg::OP_PUT, 16'h0F0F, 32'sh7654_3210);
      drain();

      caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd16};
      caps[6] = lkvc_pkg::CFG_W'($urandom_range(15, 2));
      foreach (caps[i]) begin
         idle_pct = (i == 2) ? 0 : 10;
         random_phase(caps[i], PHASE_ITEMS);
      end
      idle_pct = 10;

      $display("ran %0d requests over %0d capacity settings", shadow.requests, shadow.settings);
      $display("saw %0d hits and %0d evictions, %0d mismatches",
               shadow.hits, shadow.evictions, shadow.mismatches);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lkvc_pkg.sv
hdl/lkvc_store.sv
hdl/lru_key_value_cache.sv
tb/sv/tb.sv
